// ===== sv/sfd_pkg.sv =====
// Shared types, register indexes and constants of the staggered derivative stream block.
package sfd_pkg;

  // Default maximum grid depth and width, in points.
  localparam int unsigned SFD_MAX_DEPTH = 1024;
  localparam int unsigned SFD_MAX_WIDTH = 4096;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned DERIV_W     = 38;
  localparam int unsigned DEPTH_CFG_W = 11;
  localparam int unsigned WIDTH_CFG_W = 13;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PADDR_W     = 4;

  // Smallest grid size that the stencil supports on either axis.
  localparam int unsigned MIN_POINTS = 4;

  // Register reset values.
  localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET = DEPTH_CFG_W'(1024);
  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = WIDTH_CFG_W'(4096);

  // Stencil weights of the scaled derivative.
  localparam logic signed [DERIV_W-1:0] EDGE_GAIN  = DERIV_W'(24);
  localparam logic signed [DERIV_W-1:0] INNER_GAIN = DERIV_W'(27);

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_AXIS    = 2'd0,
    REG_FORWARD = 2'd1,
    REG_DEPTH   = 2'd2,
    REG_WIDTH   = 2'd3
  } reg_index_t;

  // Request kind on the item channel.
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_DRAIN  = 1'b1
  } kind_t;

  // Stencil form chosen for one grid point.
  typedef enum logic [1:0] {
    STENCIL_ZERO  = 2'd0,
    STENCIL_EDGE  = 2'd1,
    STENCIL_INNER = 2'd2
  } stencil_t;

endpackage

// ===== sv/staggered_fd_derivative_stream_core.sv =====
// Streaming fourth-order staggered-grid derivative core with window memory and APB registers.
//
// Channel  Dir  Handshake                    Payload
// item     in   item_valid / item_stall      kind, sample
// result   out  result_valid / result_stall  derivative, written, last
// config   in   APB psel/penable/pready      axis, forward_stagger, depth_points, width_points
//
// One request is taken per clock while item_stall is low; results pass three registered stages.
// The rate is set by the window memory: one write port and two read ports in each of its
// two copies, which serve the four stencil taps of a point in a single cycle.
// Synchronous rst clears pointers, counters, the fill count and the stage valids; the
// window is not swept, entries beyond the fill count read as zero.
// item_stall is high only while all three result stages hold data and result_stall is high.
module staggered_fd_derivative_stream_core #(
  parameter int unsigned MAX_DEPTH = sfd_pkg::SFD_MAX_DEPTH,
  parameter int unsigned MAX_WIDTH = sfd_pkg::SFD_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Item channel
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  sfd_pkg::kind_t                        kind,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]   sample,
  // Result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [sfd_pkg::DERIV_W-1:0]    derivative,
  output logic                                  written,
  output logic                                  last,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0]           paddr,
  input  logic [sfd_pkg::DATA_W-1:0]            pwdata,
  output logic [sfd_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);
  import sfd_pkg::*;

  // Window holds two columns of lookahead plus one column of history.
  localparam int unsigned WIN_DEPTH = 3 * MAX_DEPTH + 1;
  localparam int unsigned AW  = $clog2(WIN_DEPTH);
  localparam int unsigned FW  = $clog2(WIN_DEPTH + 1);
  localparam int unsigned DCW = $clog2(MAX_DEPTH);
  localparam int unsigned CCW = $clog2(MAX_WIDTH);
  localparam int unsigned PW  = $clog2(2 * MAX_DEPTH + 1);
  localparam int unsigned DW1 = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CW1 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned IW0 = (DW1 > CW1) ? DW1 : CW1;
  localparam int unsigned IW  = (IW0 > WIDTH_CFG_W) ? IW0 : WIDTH_CFG_W;
  localparam int unsigned EXT = DERIV_W - SAMPLE_W - 1;

  // Tap slots: near pair from one window copy, far pair from the other.
  localparam int unsigned TAP_NEAR_HI = 0;
  localparam int unsigned TAP_NEAR_LO = 1;
  localparam int unsigned TAP_FAR_HI  = 2;
  localparam int unsigned TAP_FAR_LO  = 3;

  // Ring arithmetic on window addresses; both operands stay below the window depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(WIN_DEPTH)) begin
      sum = sum - (AW+1)'(WIN_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] diff;
    if (a >= b) begin
      diff = {1'b0, a} - {1'b0, b};
    end else begin
      diff = {1'b0, a} + (AW+1)'(WIN_DEPTH) - {1'b0, b};
    end
    return diff[AW-1:0];
  endfunction

  // Configuration registers
  logic                   axis;
  logic                   forward_stagger;
  logic [DEPTH_CFG_W-1:0] depth_points;
  logic [WIDTH_CFG_W-1:0] width_points;

  // Stream state
  logic [AW-1:0]  wr_ptr, wr_ptr_next;
  logic [AW-1:0]  rd_ptr, rd_ptr_next;
  logic [FW-1:0]  fill, fill_next;
  logic [PW-1:0]  pending, pending_next;
  logic [DCW-1:0] depth_counter, depth_counter_next;
  logic [CCW-1:0] column_counter, column_counter_next;

  // Window memory, two copies with identical contents
  logic signed [SAMPLE_W-1:0] win_near [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] win_far  [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] near_hi_word, near_lo_word, far_hi_word, far_lo_word;

  // Stage one: read data lands here together with the point's control
  logic                       s1_valid;
  logic [3:0]                 s1_hit;
  logic [3:0]                 s1_live;
  logic signed [SAMPLE_W-1:0] s1_sample;
  stencil_t                   s1_mode;
  logic                       s1_last;

  // Stage two: the two differences
  logic                       s2_valid;
  logic signed [SAMPLE_W:0]   s2_near;
  logic signed [SAMPLE_W:0]   s2_far;
  stencil_t                   s2_mode;
  logic                       s2_last;

  // Flow control: each stage fills when it is empty or moving on.
  logic out_free, s2_free, s1_free;
  logic accept, is_sample, do_write, do_emit;

  assign out_free   = !result_valid || !result_stall;
  assign s2_free    = !s2_valid || out_free;
  assign s1_free    = !s1_valid || s2_free;
  assign item_stall = !s1_free;
  assign accept     = item_valid && !item_stall;
  assign is_sample  = (kind == KIND_SAMPLE);
  assign do_write   = accept && is_sample;

  // Clamped grid sizes
  logic [IW-1:0] nnz, nnx, dp_ext, wp_ext;

  always_comb begin
    dp_ext = IW'(depth_points);
    wp_ext = IW'(width_points);
    if (dp_ext < IW'(MIN_POINTS)) begin
      nnz = IW'(MIN_POINTS);
    end else if (dp_ext > IW'(MAX_DEPTH)) begin
      nnz = IW'(MAX_DEPTH);
    end else begin
      nnz = dp_ext;
    end
    if (wp_ext < IW'(MIN_POINTS)) begin
      nnx = IW'(MIN_POINTS);
    end else if (wp_ext > IW'(MAX_WIDTH)) begin
      nnx = IW'(MAX_WIDTH);
    end else begin
      nnx = wp_ext;
    end
  end

  // Lookahead; a sample emits once more than the lookahead is pending, a drain while any is.
  logic [PW-1:0] look;

  always_comb begin
    if (axis) begin
      look = forward_stagger ? (PW'(nnz) << 1) : PW'(nnz);
    end else begin
      look = forward_stagger ? PW'(2) : PW'(1);
    end
    if (is_sample) begin
      do_emit = accept && (pending >= look);
    end else begin
      do_emit = accept && (pending != '0);
    end
  end

  // Stencil form and frame position of the oldest pending point.
  logic [IW-1:0] idx, span;
  logic          at_end, last_d, last_c;
  stencil_t      mode;

  always_comb begin
    idx    = axis ? IW'(column_counter) : IW'(depth_counter);
    span   = axis ? nnx : nnz;
    at_end = idx >= span - IW'(1);
    last_d = IW'(depth_counter) >= nnz - IW'(1);
    last_c = IW'(column_counter) >= nnx - IW'(1);
    if (!forward_stagger) begin
      if (idx == '0) begin
        mode = STENCIL_ZERO;
      end else if (idx == IW'(1) || at_end) begin
        mode = STENCIL_EDGE;
      end else begin
        mode = STENCIL_INNER;
      end
    end else begin
      if (at_end) begin
        mode = STENCIL_ZERO;
      end else if (idx == '0 || idx == span - IW'(2)) begin
        mode = STENCIL_EDGE;
      end else begin
        mode = STENCIL_INNER;
      end
    end
  end

  // Tap addresses around the oldest pending point; stride is one column along width.
  logic [AW-1:0] stride, offset;
  logic [AW-1:0] addr_near_hi, addr_near_lo, addr_far_hi, addr_far_lo;
  logic [3:0]    hit, live;

  always_comb begin
    stride       = axis ? AW'(nnz) : AW'(1);
    offset       = forward_stagger ? stride : '0;
    addr_near_hi = ring_add(rd_ptr, offset);
    addr_near_lo = ring_sub(addr_near_hi, stride);
    addr_far_hi  = ring_add(addr_near_hi, stride);
    addr_far_lo  = ring_sub(addr_near_lo, stride);
    // The sample written at this edge is not yet in the memory read data.
    hit[TAP_NEAR_HI] = is_sample && (addr_near_hi == wr_ptr);
    hit[TAP_NEAR_LO] = is_sample && (addr_near_lo == wr_ptr);
    hit[TAP_FAR_HI]  = is_sample && (addr_far_hi == wr_ptr);
    hit[TAP_FAR_LO]  = is_sample && (addr_far_lo == wr_ptr);
    // Entries at or beyond the fill count were never written and read as zero.
    live[TAP_NEAR_HI] = FW'(addr_near_hi) < fill;
    live[TAP_NEAR_LO] = FW'(addr_near_lo) < fill;
    live[TAP_FAR_HI]  = FW'(addr_far_hi) < fill;
    live[TAP_FAR_LO]  = FW'(addr_far_lo) < fill;
  end

  // Next values of pointers, counters and the pending count.
  always_comb begin
    wr_ptr_next         = wr_ptr;
    rd_ptr_next         = rd_ptr;
    fill_next           = fill;
    pending_next        = pending;
    depth_counter_next  = depth_counter;
    column_counter_next = column_counter;
    if (do_write) begin
      wr_ptr_next = (wr_ptr == AW'(WIN_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (fill != FW'(WIN_DEPTH)) begin
        fill_next = fill + FW'(1);
      end
    end
    if (do_emit) begin
      rd_ptr_next = (rd_ptr == AW'(WIN_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (last_d) begin
        depth_counter_next  = '0;
        column_counter_next = last_c ? '0 : column_counter + CCW'(1);
      end else begin
        depth_counter_next = depth_counter + DCW'(1);
      end
    end
    if (do_write && !do_emit) begin
      pending_next = pending + PW'(1);
    end else if (!do_write && do_emit) begin
      pending_next = pending - PW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      fill           <= '0;
      pending        <= '0;
      depth_counter  <= '0;
      column_counter <= '0;
    end else begin
      wr_ptr         <= wr_ptr_next;
      rd_ptr         <= rd_ptr_next;
      fill           <= fill_next;
      pending        <= pending_next;
      depth_counter  <= depth_counter_next;
      column_counter <= column_counter_next;
    end
  end

  // Window memory: one write and two registered reads per copy.
  always_ff @(posedge clk) begin
    if (do_write) begin
      win_near[wr_ptr] <= sample;
      win_far[wr_ptr]  <= sample;
    end
    if (do_emit) begin
      near_hi_word <= win_near[addr_near_hi];
      near_lo_word <= win_near[addr_near_lo];
      far_hi_word  <= win_far[addr_far_hi];
      far_lo_word  <= win_far[addr_far_lo];
    end
  end

  // Stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= do_emit;
    end
    if (do_emit) begin
      s1_hit    <= hit;
      s1_live   <= live;
      s1_sample <= sample;
      s1_mode   <= mode;
      s1_last   <= last_d && last_c;
    end
  end

  // Tap values after bypass and zero fill, then the near and far differences.
  logic signed [SAMPLE_W-1:0] tap_near_hi, tap_near_lo, tap_far_hi, tap_far_lo;
  logic signed [SAMPLE_W:0]   near_diff, far_diff;

  always_comb begin
    tap_near_hi = s1_hit[TAP_NEAR_HI] ? s1_sample :
                  (s1_live[TAP_NEAR_HI] ? near_hi_word : '0);
    tap_near_lo = s1_hit[TAP_NEAR_LO] ? s1_sample :
                  (s1_live[TAP_NEAR_LO] ? near_lo_word : '0);
    tap_far_hi  = s1_hit[TAP_FAR_HI] ? s1_sample :
                  (s1_live[TAP_FAR_HI] ? far_hi_word : '0);
    tap_far_lo  = s1_hit[TAP_FAR_LO] ? s1_sample :
                  (s1_live[TAP_FAR_LO] ? far_lo_word : '0);
    near_diff = $signed({tap_near_hi[SAMPLE_W-1], tap_near_hi})
              - $signed({tap_near_lo[SAMPLE_W-1], tap_near_lo});
    far_diff  = $signed({tap_far_hi[SAMPLE_W-1], tap_far_hi})
              - $signed({tap_far_lo[SAMPLE_W-1], tap_far_lo});
  end

  // Stage two register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
    if (s1_valid && s2_free) begin
      s2_near <= near_diff;
      s2_far  <= far_diff;
      s2_mode <= s1_mode;
      s2_last <= s1_last;
    end
  end

  // Weighted combination: 27 near minus far inside, 24 near at the stencil edges.
  logic signed [DERIV_W-1:0] near_ext, far_ext, deriv_calc;

  always_comb begin
    near_ext = $signed({{EXT{s2_near[SAMPLE_W]}}, s2_near});
    far_ext  = $signed({{EXT{s2_far[SAMPLE_W]}}, s2_far});
    case (s2_mode)
      STENCIL_EDGE:  deriv_calc = near_ext * EDGE_GAIN;
      STENCIL_INNER: deriv_calc = near_ext * INNER_GAIN - far_ext;
      default:       deriv_calc = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s2_valid;
    end
    if (s2_valid && out_free) begin
      derivative <= deriv_calc;
      written    <= (s2_mode != STENCIL_ZERO);
      last       <= s2_last;
    end
  end

  // Configuration writes complete in the access cycle.
  reg_index_t reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis            <= 1'b0;
      forward_stagger <= 1'b0;
      depth_points    <= DEPTH_RESET;
      width_points    <= WIDTH_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_AXIS:    axis            <= pwdata[0];
        REG_FORWARD: forward_stagger <= pwdata[0];
        REG_DEPTH:   depth_points    <= pwdata[DEPTH_CFG_W-1:0];
        REG_WIDTH:   width_points    <= pwdata[WIDTH_CFG_W-1:0];
        default:     axis            <= axis;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_AXIS:    prdata = DATA_W'(axis);
      REG_FORWARD: prdata = DATA_W'(forward_stagger);
      REG_DEPTH:   prdata = DATA_W'(depth_points);
      REG_WIDTH:   prdata = DATA_W'(width_points);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== sv/sfd_checker.sv =====
// Port-level assertions for the staggered derivative stream core, bound into the core module.
module sfd_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_stall,
  input sfd_pkg::kind_t                       kind,
  input logic signed [sfd_pkg::SAMPLE_W-1:0]  sample,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [sfd_pkg::DERIV_W-1:0]   derivative,
  input logic                                 written,
  input logic                                 last,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [sfd_pkg::PADDR_W-1:0]          paddr,
  input logic [sfd_pkg::DATA_W-1:0]           pwdata,
  input logic [sfd_pkg::DATA_W-1:0]           prdata,
  input logic                                 pready
);
  import sfd_pkg::*;

  // A stalled request keeps its payload until it is taken.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=>
      item_valid && $stable(kind) && $stable(sample))
    else $error("request payload changed while stalled");

  // A stalled result keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(derivative) && $stable(written) && $stable(last))
    else $error("result payload changed while stalled");

  // The point that the stencil leaves unwritten carries a zero derivative.
  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !written |-> derivative == '0)
    else $error("unwritten point with nonzero derivative");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A write to the axis register reads back in the next cycle.
  a_axis_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_AXIS) ##1
    (psel && !pwrite && paddr[3:2] == REG_AXIS) |->
      prdata == {{(DATA_W-1){1'b0}}, $past(pwdata[0])})
    else $error("axis register readback mismatch");

endmodule

bind staggered_fd_derivative_stream_core sfd_checker u_sfd_checker (.*);
